// File: rtl/pupil_position_toward_point_unit_macros.svh
// assertion macros used by the checker file of the pupil position unit
// needs clk_i and rst_ni in the scope of each use
`ifndef PUPIL_POSITION_TOWARD_POINT_UNIT_MACROS_SVH
`define PUPIL_POSITION_TOWARD_POINT_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles, disabled during reset
`define PPT_ASSERT_LATER(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// File: rtl/ppt_pkg.sv
// shared constants, types and helpers of the pupil position unit
// no dependencies
package ppt_pkg;

  // default parameter values
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_BITS_DEF   = 12;

  // fixed field and port widths
  localparam int RADIUS_BITS   = 8;
  localparam int APB_ADDR_BITS = 5;
  localparam int APB_DATA_BITS = 32;

  // rotating cordic datapath widths
  localparam int ROT_W  = 32;
  localparam int ROT_ZW = 18;

  // angle format: one full turn is 2^16
  localparam logic [15:0] ANGLE_QUARTER  = 16'h4000;
  localparam logic [15:0] ANGLE_HALF     = 16'h8000;
  localparam logic [15:0] ANGLE_3QUARTER = 16'hC000;

  // cordic gain inverse and rounding constant in q30
  localparam logic signed [ROT_W-1:0] GAIN_INV_Q30 = 32'sd652032874;
  localparam logic [31:0]             Q30_HALF     = 32'd536870912;

  // round(atan(2^-i) * 65536 / (2*pi))
  localparam logic [15:0] ATAN_TABLE [24] = '{
    16'd8192, 16'd4836, 16'd2555, 16'd1297, 16'd651, 16'd326, 16'd163, 16'd81,
    16'd41,   16'd20,   16'd10,   16'd5,    16'd3,   16'd1,   16'd1,   16'd0,
    16'd0,    16'd0,    16'd0,    16'd0,    16'd0,   16'd0,   16'd0,   16'd0
  };

  // register reset values
  localparam int RST_LEFT_CX  = 250;
  localparam int RST_LEFT_CY  = 400;
  localparam int RST_RIGHT_CX = 700;
  localparam int RST_RIGHT_CY = 400;
  localparam int RST_RAD_X    = 30;
  localparam int RST_RAD_Y    = 60;

  // register index in the apb word address
  typedef enum logic [2:0] {
    REG_LEFT_CX  = 3'd0,
    REG_LEFT_CY  = 3'd1,
    REG_RIGHT_CX = 3'd2,
    REG_RIGHT_CY = 3'd3,
    REG_RAD_X    = 3'd4,
    REG_RAD_Y    = 3'd5
  } ppt_reg_e;

  // control traveling with the vectoring stages
  typedef struct packed {
    logic valid;
    logic zero;
  } ppt_vctl_t;

  // control traveling with the rotating stages
  typedef struct packed {
    logic valid;
    logic neg;
  } ppt_rctl_t;

  // start-to-result latency in cycles
  function automatic int ppt_latency(input int steps);
    return 2 * steps + 4;
  endfunction

endpackage

// File: rtl/ppt_vec_stage.sv
// one registered iteration of the vectoring cordic (angle of a vector)
// depends on ppt_pkg
module ppt_vec_stage import ppt_pkg::*; #(
  parameter int VW  = 31,
  parameter int IDX = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ppt_vctl_t            ctl_i,
  input  logic signed [VW-1:0] x_i,
  input  logic signed [VW-1:0] y_i,
  input  logic [15:0]          z_i,
  output ppt_vctl_t            ctl_o,
  output logic signed [VW-1:0] x_o,
  output logic signed [VW-1:0] y_o,
  output logic [15:0]          z_o
);

  logic signed [VW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic [15:0]          z_d, z_q;
  ppt_vctl_t            ctl_q;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // rotate toward the x axis, accumulate the angle modulo one turn
  always_comb begin
    if (!y_i[VW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ATAN_TABLE[IDX];
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ATAN_TABLE[IDX];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

// File: rtl/ppt_rot_stage.sv
// one registered iteration of the rotating cordic (cos and sin in q30)
// depends on ppt_pkg
module ppt_rot_stage import ppt_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ppt_rctl_t                ctl_i,
  input  logic signed [ROT_W-1:0]  x_i,
  input  logic signed [ROT_W-1:0]  y_i,
  input  logic signed [ROT_ZW-1:0] z_i,
  output ppt_rctl_t                ctl_o,
  output logic signed [ROT_W-1:0]  x_o,
  output logic signed [ROT_W-1:0]  y_o,
  output logic signed [ROT_ZW-1:0] z_o
);

  logic signed [ROT_W-1:0]  xs, ys, x_d, y_d, x_q, y_q;
  logic signed [ROT_ZW-1:0] atan, z_d, z_q;
  ppt_rctl_t                ctl_q;

  assign xs   = x_i >>> IDX;
  assign ys   = y_i >>> IDX;
  assign atan = {{(ROT_ZW-16){1'b0}}, ATAN_TABLE[IDX]};

  // rotate by the residual angle
  always_comb begin
    if (!z_i[ROT_ZW-1]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.valid) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign ctl_o = ctl_q;
  assign x_o   = x_q;
  assign y_o   = y_q;
  assign z_o   = z_q;

endmodule

// File: rtl/ppt_lane.sv
// full pipeline for one eye: offset, vectoring chain, rotating chain, scale, place
// depends on ppt_pkg, ppt_vec_stage, ppt_rot_stage
module ppt_lane import ppt_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] cx_i,
  input  logic signed [COORD_BITS-1:0] cy_i,
  input  logic [RADIUS_BITS-1:0]       rad_x_i,
  input  logic [RADIUS_BITS-1:0]       rad_y_i,
  output logic                         valid_o,
  output logic signed [COORD_BITS-1:0] pupil_x_o,
  output logic signed [COORD_BITS-1:0] pupil_y_o
);

  localparam int DW  = COORD_BITS + 1;
  localparam int VW  = COORD_BITS + 19;
  localparam int PW  = ROT_W + RADIUS_BITS + 1;
  localparam int OFW = PW - 30;
  localparam int OW  = COORD_BITS + 2;
  localparam int N   = CORDIC_STEPS;

  localparam logic signed [ROT_ZW-1:0] Z_QUARTER  = {2'b00, ANGLE_QUARTER};
  localparam logic signed [ROT_ZW-1:0] Z_NQUARTER = -Z_QUARTER;
  localparam logic signed [ROT_ZW-1:0] Z_HALF     = {2'b00, ANGLE_HALF};
  localparam logic signed [PW-1:0]     RND        = PW'(Q30_HALF);
  localparam logic signed [COORD_BITS-1:0] SAT_HI = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] SAT_LO = {1'b1, {(COORD_BITS-1){1'b0}}};

  // round, add to the centre, saturate to the coordinate range
  function automatic logic signed [COORD_BITS-1:0] place(
    input logic signed [COORD_BITS-1:0] c,
    input logic signed [PW-1:0]         p
  );
    logic signed [PW-1:0]  r;
    logic signed [OFW-1:0] off;
    logic signed [OW-1:0]  v;
    r   = p + RND;
    off = r[PW-1:30];
    v   = {{(OW-COORD_BITS){c[COORD_BITS-1]}}, c} + {{(OW-OFW){off[OFW-1]}}, off};
    if (v[OW-1:COORD_BITS-1] == '0 || v[OW-1:COORD_BITS-1] == '1) begin
      return v[COORD_BITS-1:0];
    end else if (v[OW-1]) begin
      return SAT_LO;
    end else begin
      return SAT_HI;
    end
  endfunction

  // offset and quarter-turn pre-rotation so that x is not negative
  logic signed [DW-1:0] dx, dy;
  logic signed [VW-1:0] sx, sy, x0_d, y0_d;
  logic [15:0]          z0_d;

  assign dx = {px_i[COORD_BITS-1], px_i} - {cx_i[COORD_BITS-1], cx_i};
  assign dy = {py_i[COORD_BITS-1], py_i} - {cy_i[COORD_BITS-1], cy_i};
  assign sx = {{(VW-DW-16){dx[DW-1]}}, dx, 16'h0000};
  assign sy = {{(VW-DW-16){dy[DW-1]}}, dy, 16'h0000};

  always_comb begin
    x0_d = sx;
    y0_d = sy;
    z0_d = '0;
    if (dx[DW-1]) begin
      if (!dy[DW-1]) begin
        x0_d = sy;
        y0_d = -sx;
        z0_d = ANGLE_QUARTER;
      end else begin
        x0_d = -sy;
        y0_d = sx;
        z0_d = ANGLE_3QUARTER;
      end
    end
  end

  ppt_vctl_t            vctl [N+1];
  logic signed [VW-1:0] vx   [N+1];
  logic signed [VW-1:0] vy   [N+1];
  logic [15:0]          vz   [N+1];
  ppt_vctl_t            vctl0_q;
  logic signed [VW-1:0] vx0_q, vy0_q;
  logic [15:0]          vz0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vctl0_q <= '0;
    end else begin
      vctl0_q.valid <= valid_i;
      vctl0_q.zero  <= (dx == '0) && (dy == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      vx0_q <= x0_d;
      vy0_q <= y0_d;
      vz0_q <= z0_d;
    end
  end

  assign vctl[0] = vctl0_q;
  assign vx[0]   = vx0_q;
  assign vy[0]   = vy0_q;
  assign vz[0]   = vz0_q;

  // vectoring chain, one iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_vec
    ppt_vec_stage #(.VW(VW), .IDX(i)) u_vec (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (vctl[i]),
      .x_i   (vx[i]),
      .y_i   (vy[i]),
      .z_i   (vz[i]),
      .ctl_o (vctl[i+1]),
      .x_o   (vx[i+1]),
      .y_o   (vy[i+1]),
      .z_o   (vz[i+1])
    );
  end

  // angle reduction to within a quarter turn, remembering the half-turn flip
  logic [15:0]              ang;
  logic signed [ROT_ZW-1:0] zs, rz0_d;
  logic                     neg_d;

  assign ang = vctl[N].zero ? 16'h0000 : vz[N];
  assign zs  = {{(ROT_ZW-16){ang[15]}}, ang};

  always_comb begin
    rz0_d = zs;
    neg_d = 1'b0;
    if (zs > Z_QUARTER) begin
      rz0_d = zs - Z_HALF;
      neg_d = 1'b1;
    end else if (zs < Z_NQUARTER) begin
      rz0_d = zs + Z_HALF;
      neg_d = 1'b1;
    end
  end

  ppt_rctl_t                rctl [N+1];
  logic signed [ROT_W-1:0]  rx   [N+1];
  logic signed [ROT_W-1:0]  ry   [N+1];
  logic signed [ROT_ZW-1:0] rz   [N+1];
  ppt_rctl_t                rctl0_q;
  logic signed [ROT_ZW-1:0] rz0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rctl0_q <= '0;
    end else begin
      rctl0_q.valid <= vctl[N].valid;
      rctl0_q.neg   <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vctl[N].valid) begin
      rz0_q <= rz0_d;
    end
  end

  assign rctl[0] = rctl0_q;
  assign rx[0]   = GAIN_INV_Q30;
  assign ry[0]   = '0;
  assign rz[0]   = rz0_q;

  // rotating chain, one iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_rot
    ppt_rot_stage #(.IDX(i)) u_rot (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (rctl[i]),
      .x_i   (rx[i]),
      .y_i   (ry[i]),
      .z_i   (rz[i]),
      .ctl_o (rctl[i+1]),
      .x_o   (rx[i+1]),
      .y_o   (ry[i+1]),
      .z_o   (rz[i+1])
    );
  end

  // scale cos and sin by the orbit radii
  logic signed [ROT_W-1:0] cq, sq;
  logic signed [PW-1:0]    prod_x_q, prod_y_q;
  logic                    mul_valid_q;

  assign cq = rctl[N].neg ? -rx[N] : rx[N];
  assign sq = rctl[N].neg ? -ry[N] : ry[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else begin
      mul_valid_q <= rctl[N].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rctl[N].valid) begin
      prod_x_q <= $signed({1'b0, rad_x_i}) * cq;
      prod_y_q <= $signed({1'b0, rad_y_i}) * sq;
    end
  end

  // result register
  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] pupil_x_q, pupil_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_valid_q) begin
      pupil_x_q <= place(cx_i, prod_x_q);
      pupil_y_q <= place(cy_i, prod_y_q);
    end
  end

  assign valid_o   = out_valid_q;
  assign pupil_x_o = pupil_x_q;
  assign pupil_y_o = pupil_y_q;

endmodule

// File: rtl/pupil_position_toward_point_unit.sv
// top level of the pupil position unit: register file and two eye lanes
// depends on ppt_pkg and ppt_lane
//
// Usage
//   A pointer position is presented on pointer_x_i/pointer_y_i with start
//   high; it is taken at any clock edge where start is high and busy is low.
//   busy stays low, so a new position can be started in every cycle.
//   For each of the two eye centres the unit takes the direction toward the
//   pointer and returns the point on the orbit ellipse around that centre.
//   Results appear on the four pupil ports with done_o high for one cycle,
//   once the start has passed the offset register, the vectoring chain,
//   the reduction register, the rotating chain (each chain one stage per
//   iteration), and the multiply and output registers.
//   Throughput is one position per cycle. The receiver cannot stall: every
//   result must be taken in the cycle it is shown.
//   Centres and radii sit in apb registers that the user must write only
//   while no position is in flight; the block does not enforce it. Reset
//   clears the pipeline (no done_o strobes), loads default centres and radii.
module pupil_position_toward_point_unit import ppt_pkg::*; #(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] pointer_x_i,
  input  logic signed [COORD_BITS-1:0] pointer_y_i,
  output logic                         done_o,
  output logic signed [COORD_BITS-1:0] left_pupil_x_o,
  output logic signed [COORD_BITS-1:0] left_pupil_y_o,
  output logic signed [COORD_BITS-1:0] right_pupil_x_o,
  output logic signed [COORD_BITS-1:0] right_pupil_y_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_ADDR_BITS-1:0]     paddr,
  input  logic [APB_DATA_BITS-1:0]     pwdata,
  output logic [APB_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  logic signed [COORD_BITS-1:0] left_cx_q, left_cy_q, right_cx_q, right_cy_q;
  logic [RADIUS_BITS-1:0]       rad_x_q, rad_y_q;
  logic                         wr_en, accept;
  ppt_reg_e                     reg_idx;
  logic                         l_valid, r_valid;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = ppt_reg_e'(paddr[APB_ADDR_BITS-1:2]);

  // register writes on the access phase of an apb transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_cx_q  <= COORD_BITS'(RST_LEFT_CX);
      left_cy_q  <= COORD_BITS'(RST_LEFT_CY);
      right_cx_q <= COORD_BITS'(RST_RIGHT_CX);
      right_cy_q <= COORD_BITS'(RST_RIGHT_CY);
      rad_x_q    <= RADIUS_BITS'(RST_RAD_X);
      rad_y_q    <= RADIUS_BITS'(RST_RAD_Y);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LEFT_CX:  left_cx_q  <= pwdata[COORD_BITS-1:0];
        REG_LEFT_CY:  left_cy_q  <= pwdata[COORD_BITS-1:0];
        REG_RIGHT_CX: right_cx_q <= pwdata[COORD_BITS-1:0];
        REG_RIGHT_CY: right_cy_q <= pwdata[COORD_BITS-1:0];
        REG_RAD_X:    rad_x_q    <= pwdata[RADIUS_BITS-1:0];
        REG_RAD_Y:    rad_y_q    <= pwdata[RADIUS_BITS-1:0];
        default:      ;
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (reg_idx)
      REG_LEFT_CX:  prdata = APB_DATA_BITS'(unsigned'(left_cx_q));
      REG_LEFT_CY:  prdata = APB_DATA_BITS'(unsigned'(left_cy_q));
      REG_RIGHT_CX: prdata = APB_DATA_BITS'(unsigned'(right_cx_q));
      REG_RIGHT_CY: prdata = APB_DATA_BITS'(unsigned'(right_cy_q));
      REG_RAD_X:    prdata = APB_DATA_BITS'(rad_x_q);
      REG_RAD_Y:    prdata = APB_DATA_BITS'(rad_y_q);
      default:      prdata = '0;
    endcase
  end

  // first eye
  ppt_lane #(.COORD_BITS(COORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .px_i     (pointer_x_i),
    .py_i     (pointer_y_i),
    .cx_i     (left_cx_q),
    .cy_i     (left_cy_q),
    .rad_x_i  (rad_x_q),
    .rad_y_i  (rad_y_q),
    .valid_o  (l_valid),
    .pupil_x_o(left_pupil_x_o),
    .pupil_y_o(left_pupil_y_o)
  );

  // second eye
  ppt_lane #(.COORD_BITS(COORD_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (accept),
    .px_i     (pointer_x_i),
    .py_i     (pointer_y_i),
    .cx_i     (right_cx_q),
    .cy_i     (right_cy_q),
    .rad_x_i  (rad_x_q),
    .rad_y_i  (rad_y_q),
    .valid_o  (r_valid),
    .pupil_x_o(right_pupil_x_o),
    .pupil_y_o(right_pupil_y_o)
  );

  // both lanes run in lockstep
  assign done_o = l_valid && r_valid;

endmodule

// File: rtl/ppt_checker.sv
// port-level checks of the pupil position unit, bound to the top level
// depends on ppt_pkg and pupil_position_toward_point_unit_macros.svh
`include "pupil_position_toward_point_unit_macros.svh"

module ppt_checker import ppt_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic psel,
  input logic pready
);

  localparam int LAT = ppt_latency(CORDIC_STEPS);

  // the pipeline never holds off a start
  `PPT_ASSERT_NOW(busy_never_a, 1'b1, !busy, "busy raised by a fully pipelined unit")

  // apb transfers complete without wait states
  `PPT_ASSERT_NOW(pready_high_a, psel, pready, "apb transfer stretched")

  // every start gives a result after the latency given by ppt_latency
  `PPT_ASSERT_LATER(start_to_done_a, start && !busy, LAT, done_o, "result missing")

  // no result without a start at the matching cycle
  `PPT_ASSERT_NOW(done_from_start_a, done_o, $past(start && !busy, LAT), "spurious result")

endmodule

bind pupil_position_toward_point_unit ppt_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_ppt_checker (.*);
